/* rtl/core/rars_pkg.sv */
// Shared constants and controller/datapath interface types for the range add / range sum block.
`timescale 1ns / 1ps
package rars_pkg;

  localparam int ENTRIES    = 4096;
  localparam int BLOCK_SIZE = 64;
  localparam int BLOCKS     = (ENTRIES + BLOCK_SIZE - 1) / BLOCK_SIZE;

  localparam int RANGE_W = 12;
  localparam int DELTA_W = 32;
  localparam int SUM_W   = 64;

  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int BLK_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int BLKC_W = $clog2(BLOCKS + 1);
  localparam int IDX_W  = $clog2(BLOCKS * BLOCK_SIZE + 1);
  localparam int CMP_W  = (IDX_W > RANGE_W) ? IDX_W : RANGE_W;
  localparam int CNT_W  = $clog2(BLOCK_SIZE + 1);

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic clr;
    logic load;
    logic advance;
    logic scan;
    logic mul;
    logic wb;
    logic issue;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic in_empty;
    logic query;
    logic scan_done;
    logic scan_skip;
    logic whole;
    logic elem_last;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/core/range_add_range_sum.sv */
// Square-root decomposition range add / range sum engine, top level.
// Items are taken one at a time: item_ready stays low until the current item is finished.
// Work per item is set by the per-block read/multiply/write-back loop and the element
//   memory walk over partly covered blocks.
// Reset: synchronous; a clearing pass over all ENTRIES (4096) addresses zeroes both
//   memories, with item_ready low until it ends.
// A result beat waits in an output register.
`timescale 1ns / 1ps
module range_add_range_sum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic                                mode,
  input  logic        [rars_pkg::RANGE_W-1:0] range_lo,
  input  logic        [rars_pkg::RANGE_W-1:0] range_hi,
  input  logic signed [rars_pkg::DELTA_W-1:0] delta,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [rars_pkg::SUM_W-1:0]   range_sum
);
  import rars_pkg::*;

  ctl_t ctl;
  sts_t sts;

  rars_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  rars_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .mode         (mode),
    .range_lo     (range_lo),
    .range_hi     (range_hi),
    .delta        (delta),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .range_sum    (range_sum)
  );

endmodule

/* rtl/core/rars_ctrl.sv */
// Sequencing state machine: clearing pass, block walk, element walk and result hand-off.
`timescale 1ns / 1ps
module rars_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  rars_pkg::sts_t sts,
  output rars_pkg::ctl_t ctl
);
  import rars_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_WB    = 8'b0001_0000,
    ST_ELEM  = 8'b0010_0000,
    ST_DRAIN = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_CLEAR: begin
        ctl.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          ctl.load   = 1'b1;
          state_next = sts.in_empty ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_DONE;
        end else if (sts.scan_skip) begin
          ctl.advance = 1'b1;
        end else begin
          ctl.scan   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        ctl.wb = 1'b1;
        if (sts.whole) begin
          ctl.advance = 1'b1;
          state_next  = ST_SCAN;
        end else begin
          state_next = ST_ELEM;
        end
      end
      ST_ELEM: begin
        ctl.issue = 1'b1;
        if (sts.elem_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ctl.advance = 1'b1;
        state_next  = ST_SCAN;
      end
      ST_DONE: begin
        if (!sts.query) begin
          state_next = ST_IDLE;
        end else if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/rars_dpath.sv */
// Datapath: element and block memories, range bounds, multiplier, accumulator, result register.
`timescale 1ns / 1ps
module rars_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  rars_pkg::ctl_t                      ctl,
  output rars_pkg::sts_t                      sts,
  input  logic                                mode,
  input  logic        [rars_pkg::RANGE_W-1:0] range_lo,
  input  logic        [rars_pkg::RANGE_W-1:0] range_hi,
  input  logic signed [rars_pkg::DELTA_W-1:0] delta,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [rars_pkg::SUM_W-1:0]   range_sum
);
  import rars_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] tag;
    logic [SUM_W-1:0] sum;
  } blk_word_t;

  logic [SUM_W-1:0] elem_mem [ENTRIES];
  blk_word_t        blk_mem  [BLOCKS];

  logic [ADDR_W-1:0] clr_cnt;
  logic              op_query;
  logic [IDX_W-1:0]  a;
  logic [IDX_W-1:0]  b;
  logic [SUM_W-1:0]  d64;
  logic [BLKC_W-1:0] blk;
  logic [IDX_W-1:0]  first;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  e_r;
  logic [CNT_W-1:0]  n_r;
  logic              whole_r;
  blk_word_t         blk_rdata;
  logic [SUM_W-1:0]  elem_rdata;
  logic [SUM_W-1:0]  prod;
  logic [SUM_W-1:0]  acc;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;

  logic [CMP_W-1:0]  lo_w;
  logic [CMP_W-1:0]  hi_w;
  logic [CMP_W-1:0]  hi_clip;
  logic [IDX_W-1:0]  last_raw;
  logic [IDX_W-1:0]  last;
  logic [IDX_W-1:0]  s_c;
  logic [IDX_W-1:0]  e_c;
  logic              whole_c;
  logic [SUM_W-1:0]  op_val;

  assign lo_w    = CMP_W'(range_lo);
  assign hi_w    = CMP_W'(range_hi);
  assign hi_clip = (hi_w > CMP_W'(ENTRIES - 1)) ? CMP_W'(ENTRIES - 1) : hi_w;

  assign last_raw = first + IDX_W'(BLOCK_SIZE - 1);
  assign last     = (last_raw > IDX_W'(ENTRIES - 1)) ? IDX_W'(ENTRIES - 1) : last_raw;
  assign s_c      = (a > first) ? a : first;
  assign e_c      = (b < last) ? b : last;
  assign whole_c  = (a <= first) && (b >= last);
  assign op_val   = op_query ? blk_rdata.tag : d64;

  assign sts.clr_last  = (clr_cnt == ADDR_W'(ENTRIES - 1));
  assign sts.in_empty  = (lo_w > hi_w) || (lo_w >= CMP_W'(ENTRIES));
  assign sts.query     = op_query;
  assign sts.scan_done = (blk == BLKC_W'(BLOCKS)) || (first > b);
  assign sts.scan_skip = (last < a);
  assign sts.whole     = whole_r;
  assign sts.elem_last = (j == e_r);
  assign sts.out_busy  = result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clr) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_query <= (mode == MODE_QUERY);
      a        <= IDX_W'(lo_w);
      b        <= IDX_W'(hi_clip);
      d64      <= {{(SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta};
      blk      <= '0;
      first    <= '0;
    end else if (ctl.advance) begin
      blk   <= blk + BLKC_W'(1);
      first <= first + IDX_W'(BLOCK_SIZE);
    end
    if (ctl.scan) begin
      j       <= s_c;
      e_r     <= e_c;
      n_r     <= CNT_W'(e_c - s_c + IDX_W'(1));
      whole_r <= whole_c;
    end else if (ctl.issue) begin
      j <= j + IDX_W'(1);
    end
    if (ctl.mul) begin
      prod <= op_val * SUM_W'(n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= '0;
    end else if (ctl.wb && op_query) begin
      acc <= acc + (whole_r ? blk_rdata.sum : prod);
    end else if (pend && op_query) begin
      acc <= acc + elem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= ctl.issue;
    end
    pend_addr <= j[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    blk_rdata <= blk_mem[blk[BLK_W-1:0]];
    if (ctl.clr) begin
      if ((ADDR_W + 1)'(clr_cnt) < (ADDR_W + 1)'(BLOCKS)) begin
        blk_mem[clr_cnt[BLK_W-1:0]] <= '0;
      end
    end else if (ctl.wb && !op_query) begin
      blk_mem[blk[BLK_W-1:0]] <= '{tag: blk_rdata.tag + (whole_r ? d64 : '0),
                                   sum: blk_rdata.sum + prod};
    end
  end

  always_ff @(posedge clk) begin
    elem_rdata <= elem_mem[j[ADDR_W-1:0]];
    if (ctl.clr) begin
      elem_mem[clr_cnt] <= '0;
    end else if (pend && !op_query) begin
      elem_mem[pend_addr] <= elem_rdata + d64;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (ctl.out_load) begin
      range_sum <= acc;
    end
  end

endmodule
